>>> rtl/sta_pkg.sv
`default_nettype none

package sta_pkg;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int QUEUE_DEPTH = 2;
  localparam int SLOT_W = 7;
  localparam int TOTAL_W = 8;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [47:0]        mac_address;
    logic signed [7:0]  signal_strength;
    logic [31:0]        now_seconds;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [SLOT_W-1:0]    slot_index;
    logic [COUNT_W-1:0]   seen_count;
    logic signed [7:0]    peak_strength;
    logic [TOTAL_W-1:0]   entry_total;
  } out_t;

  typedef struct packed {
    logic valid;
    in_t  item;
  } queue_head_t;

endpackage

`default_nettype wire

>>> rtl/sta_front.sv
`default_nettype none

module sta_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire sta_pkg::in_t       in_data,
  output sta_pkg::queue_head_t    head,
  input  wire logic               pop
);

  localparam int QPTR_W = (sta_pkg::QUEUE_DEPTH > 1) ? $clog2(sta_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(sta_pkg::QUEUE_DEPTH + 1);

  sta_pkg::in_t      q_r [sta_pkg::QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              do_pop;

  assign busy   = (cnt_r == QCNT_W'(sta_pkg::QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(sta_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(sta_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sta_back.sv
`default_nettype none

module sta_back #(
  parameter int TABLE_ENTRIES = sta_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sta_pkg::queue_head_t  head,
  output logic                       pop,
  output logic                       out_valid,
  output sta_pkg::out_t              out_data
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_FETCH  = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  logic [47:0]                mem_mac   [TABLE_ENTRIES];
  logic [31:0]                mem_first [TABLE_ENTRIES];
  logic [31:0]                mem_last  [TABLE_ENTRIES];
  logic [sta_pkg::COUNT_W-1:0] mem_cnt  [TABLE_ENTRIES];
  logic [7:0]                 mem_peak  [TABLE_ENTRIES];

  state_t                      state_r, state_nxt;
  sta_pkg::in_t                cur_r, cur_nxt;
  logic [IDX_W-1:0]            addr_r, addr_nxt;
  logic                        issue_r, issue_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]            chk_idx_r, chk_idx_nxt;
  logic                        found_r, found_nxt;
  logic [IDX_W-1:0]            match_r, match_nxt;
  logic [31:0]                 min_r, min_nxt;
  logic [IDX_W-1:0]            min_idx_r, min_idx_nxt;
  logic [CNT_W-1:0]            live_r, live_nxt;
  logic [IDX_W-1:0]            slot_r, slot_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sta_pkg::out_t               out_data_r, out_data_nxt;

  logic [47:0]                 rd_mac_r;
  logic [31:0]                 rd_first_r;
  logic [sta_pkg::COUNT_W-1:0] rd_cnt_r;
  logic signed [7:0]           rd_peak_r;

  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            slot_sel;
  logic [CNT_W-1:0]            live_m1;
  logic                        full;
  logic                        wr_new;
  logic                        wr_upd;
  logic [sta_pkg::COUNT_W-1:0] new_cnt;
  logic signed [7:0]           new_peak;

  assign live_m1  = live_r - 1'b1;
  assign full     = (live_r == CNT_W'(TABLE_ENTRIES));
  assign slot_sel = found_r ? match_r : (full ? min_idx_r : IDX_W'(live_r));
  assign rd_addr  = (state_r == S_SCAN) ? addr_r : slot_sel;

  assign wr_upd = (state_r == S_UPDATE);
  assign wr_new = wr_upd && !found_r;

  always_comb begin
    if (found_r) begin
      new_cnt  = (rd_cnt_r == sta_pkg::COUNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1;
      new_peak = ($signed(cur_r.signal_strength) > $signed(rd_peak_r)) ?
                 cur_r.signal_strength : rd_peak_r;
    end else begin
      new_cnt  = sta_pkg::COUNT_W'(1);
      new_peak = cur_r.signal_strength;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    addr_nxt      = addr_r;
    issue_nxt     = issue_r;
    chk_vld_nxt   = chk_vld_r;
    chk_idx_nxt   = chk_idx_r;
    found_nxt     = found_r;
    match_nxt     = match_r;
    min_nxt       = min_r;
    min_idx_nxt   = min_idx_r;
    live_nxt      = live_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        chk_vld_nxt = 1'b0;
        found_nxt   = 1'b0;
        if (head.valid) begin
          pop       = 1'b1;
          cur_nxt   = head.item;
          addr_nxt  = '0;
          issue_nxt = 1'b1;
          state_nxt = (live_r == '0) ? S_FETCH : S_SCAN;
        end
      end
      S_SCAN: begin
        chk_vld_nxt = issue_r;
        chk_idx_nxt = addr_r;
        if (issue_r) begin
          if (CNT_W'(addr_r) == live_m1) begin
            issue_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (chk_vld_r) begin
          if (!found_r && (rd_mac_r == cur_r.mac_address)) begin
            found_nxt = 1'b1;
            match_nxt = chk_idx_r;
          end
          if ((chk_idx_r == '0) || (rd_first_r < min_r)) begin
            min_nxt     = rd_first_r;
            min_idx_nxt = chk_idx_r;
          end
          if (CNT_W'(chk_idx_r) == live_m1) begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        slot_nxt  = slot_sel;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        if (!found_r && !full) begin
          live_nxt = live_r + 1'b1;
        end
        out_valid_nxt              = 1'b1;
        out_data_nxt.hit           = found_r;
        out_data_nxt.evicted       = !found_r && full;
        out_data_nxt.slot_index    = sta_pkg::SLOT_W'(slot_r);
        out_data_nxt.seen_count    = new_cnt;
        out_data_nxt.peak_strength = new_peak;
        out_data_nxt.entry_total   = sta_pkg::TOTAL_W'(live_nxt);
        state_nxt                  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      chk_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      chk_vld_r   <= chk_vld_nxt;
      found_r     <= found_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    addr_r     <= addr_nxt;
    chk_idx_r  <= chk_idx_nxt;
    match_r    <= match_nxt;
    min_r      <= min_nxt;
    min_idx_r  <= min_idx_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    rd_mac_r   <= mem_mac[rd_addr];
    rd_first_r <= mem_first[rd_addr];
    rd_cnt_r   <= mem_cnt[rd_addr];
    rd_peak_r  <= mem_peak[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_new) begin
      mem_mac[slot_r]   <= cur_r.mac_address;
      mem_first[slot_r] <= cur_r.now_seconds;
    end
    if (wr_upd) begin
      mem_last[slot_r] <= cur_r.now_seconds;
      mem_cnt[slot_r]  <= new_cnt;
      mem_peak[slot_r] <= new_peak;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(TABLE_ENTRIES))
    else $error("Live entry count exceeds the table size.");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.hit |-> !out_data_r.evicted)
    else $error("A hit result also reports an eviction.");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.evicted |-> full)
    else $error("An eviction was reported with free slots left.");

  a_live_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> $stable(live_r) || out_valid_r)
    else $error("Live entry count changed without a result transfer.");

endmodule

`default_nettype wire

>>> rtl/sighting_table_upsert_evict_oldest.sv
// Sighting table: each accepted sighting is looked up by MAC address in a table of
// TABLE_ENTRIES entries, updated on a hit, or written to the next free slot, or, when the
// table is full, over the entry with the earliest first-seen time (lowest slot on a tie).
// Items are accepted while busy is low; a two-deep queue holds them ahead of the lookup
// engine, and busy rises only when that queue is full. The engine reads one table entry
// per cycle through a single memory read port while it scans, and it takes the next item
// from the queue only once the current one is done.
// Exactly one result is produced per item, in order, shown for a single cycle with
// out_valid high; the receiver cannot stall, so it must take every transfer as it comes.
`default_nettype none

module sighting_table_upsert_evict_oldest #(
  parameter int TABLE_ENTRIES = sta_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire sta_pkg::in_t  in_data,
  output logic               out_valid,
  output sta_pkg::out_t      out_data
);

  sta_pkg::queue_head_t head;
  logic                 pop;

  sta_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .head    (head),
    .pop     (pop)
  );

  sta_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/sighting_table_upsert_evict_oldest_test.sv
`timescale 1ns / 1ps

module sighting_table_upsert_evict_oldest_test;

  localparam int TABLE_SIZE = sta_pkg::TABLE_ENTRIES_DEF;
  localparam int SATURATE_HITS = 12;
  localparam int RANDOM_SIGHTINGS = 1200;
  localparam int SETTLE_CYCLES = TABLE_SIZE + 16;
  localparam longint CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sta_pkg::in_t in_data = '0;
  logic out_valid;
  sta_pkg::out_t out_data;

  sighting_table_upsert_evict_oldest DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  // Local copy of the sighting table.
  logic [47:0] tbl_mac [TABLE_SIZE];
  logic [31:0] tbl_first [TABLE_SIZE];
  logic [31:0] tbl_last [TABLE_SIZE];
  logic [sta_pkg::COUNT_W-1:0] tbl_count [TABLE_SIZE];
  logic signed [7:0] tbl_peak [TABLE_SIZE];
  int live_total = 0;

  sta_pkg::in_t sighting_pending_q [$];
  sta_pkg::out_t sighting_expect_q [$];
  logic [47:0] recent_macs [$];
  bit used_macs [logic [47:0]];

  int error_count = 0;
  int sent_total = 0;
  int taken_total = 0;
  int burst_left = 1;
  int gap_left = 0;
  longint cycle_count = 0;

  function automatic sta_pkg::out_t predict_sighting(sta_pkg::in_t s);
    sta_pkg::out_t r;
    int slot;
    bit found;
    bit evict;
    logic signed [7:0] strength;
    strength = s.signal_strength;
    slot = 0;
    found = 1'b0;
    evict = 1'b0;
    for (int i = 0; i < live_total && i < TABLE_SIZE; i++) begin
      if (!found && tbl_mac[i] == s.mac_address) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      tbl_last[slot] = s.now_seconds;
      if (tbl_count[slot] != sta_pkg::COUNT_MAX) tbl_count[slot] = tbl_count[slot] + 1'b1;
      if ($signed(strength) > $signed(tbl_peak[slot])) tbl_peak[slot] = strength;
    end else begin
      if (live_total < TABLE_SIZE) begin
        slot = live_total;
        live_total++;
      end else begin
        slot = 0;
        for (int i = 1; i < TABLE_SIZE; i++) begin
          if (tbl_first[i] < tbl_first[slot]) slot = i;
        end
        evict = 1'b1;
      end
      tbl_mac[slot] = s.mac_address;
      tbl_first[slot] = s.now_seconds;
      tbl_last[slot] = s.now_seconds;
      tbl_count[slot] = sta_pkg::COUNT_W'(1);
      tbl_peak[slot] = strength;
    end
    r.hit = found;
    r.evicted = evict;
    r.slot_index = slot[sta_pkg::SLOT_W-1:0];
    r.seen_count = tbl_count[slot];
    r.peak_strength = tbl_peak[slot];
    r.entry_total = live_total[sta_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  function automatic logic [47:0] random_mac();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  task automatic queue_sighting(logic [47:0] mac, logic [7:0] strength, logic [31:0] now);
    sta_pkg::in_t s;
    s.mac_address = mac;
    s.signal_strength = strength;
    s.now_seconds = now;
    sighting_pending_q.push_back(s);
    recent_macs.push_back(mac);
    if (recent_macs.size() > 2 * TABLE_SIZE) void'(recent_macs.pop_front());
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Driver: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && taken_total < sent_total)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (sighting_pending_q.size() > 0) begin
        in_data <= sighting_pending_q.pop_front();
        start <= 1'b1;
        sent_total++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results are checked before the input transfer of the same edge is recorded.
  always @(posedge clk) begin
    sta_pkg::out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (sighting_expect_q.size() == 0) begin
          report_mismatch("result with nothing expected", 64'(out_data.slot_index), 64'(0));
        end else begin
          want = sighting_expect_q.pop_front();
          if (out_data.hit !== want.hit)
            report_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
          if (out_data.evicted !== want.evicted)
            report_mismatch("evicted", 64'(out_data.evicted), 64'(want.evicted));
          if (out_data.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(out_data.slot_index), 64'(want.slot_index));
          if (out_data.seen_count !== want.seen_count)
            report_mismatch("seen_count", 64'(out_data.seen_count), 64'(want.seen_count));
          if (out_data.peak_strength !== want.peak_strength)
            report_mismatch("peak_strength", 64'(out_data.peak_strength),
                            64'(want.peak_strength));
          if (out_data.entry_total !== want.entry_total)
            report_mismatch("entry_total", 64'(out_data.entry_total), 64'(want.entry_total));
        end
      end
      if (start && !busy) begin
        sighting_expect_q.push_back(predict_sighting(in_data));
        taken_total++;
      end
    end
  end

  initial begin
    logic [47:0] mac;
    logic [31:0] clock_now;
    int pick;
    int idx;

    // Extremes of every field, then peak raised on a stronger sighting and kept on equal and weaker ones.
    queue_sighting(48'h0, 8'h80, 32'h0);
    queue_sighting(48'hFFFF_FFFF_FFFF, 8'h7F, 32'hFFFF_FFFF);
    queue_sighting(48'h0, 8'h80, 32'h1);
    queue_sighting(48'h0, 8'h05, 32'h2);
    queue_sighting(48'h0, 8'hFD, 32'h3);
    queue_sighting(48'hFFFF_FFFF_FFFF, 8'h80, 32'h0);
    used_macs[48'h0] = 1'b1;
    used_macs[48'hFFFF_FFFF_FFFF] = 1'b1;

    // Repeat one entry while the table is small.
    for (int i = 0; i < SATURATE_HITS; i++)
      queue_sighting(48'h0, 8'($urandom_range(0, 255)), 32'(i + 4));

    // Fill the table, with several entries sharing the earliest first-seen time.
    for (int i = 2; i < TABLE_SIZE; i++) begin
      do mac = random_mac(); while (used_macs.exists(mac));
      used_macs[mac] = 1'b1;
      queue_sighting(mac, 8'($urandom_range(0, 255)), (i % 5 == 0) ? 32'h0 : 32'(i));
    end

    // Evictions on a full table, ties going to the lowest slot.
    for (int i = 0; i < 4; i++) begin
      do mac = random_mac(); while (used_macs.exists(mac));
      used_macs[mac] = 1'b1;
      queue_sighting(mac, 8'($urandom_range(0, 255)), (i == 2) ? 32'h0 : 32'd500);
    end
    queue_sighting(mac, 8'h7F, 32'd501);
    queue_sighting(48'hFFFF_FFFF_FFFF, 8'h7F, 32'd502);

    clock_now = 32'd600;
    for (int i = 0; i < RANDOM_SIGHTINGS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        mac = recent_macs[$urandom_range(0, recent_macs.size() - 1)];
      end else if (pick < 85) begin
        mac = random_mac();
      end else if (pick < 92) begin
        idx = $urandom_range(0, 47);
        mac = recent_macs[$urandom_range(0, recent_macs.size() - 1)] ^ (48'h1 << idx);
      end else begin
        case ($urandom_range(0, 3))
          0: mac = 48'h0;
          1: mac = 48'hFFFF_FFFF_FFFF;
          2: mac = 48'h1 << $urandom_range(0, 47);
          default: mac = ~(48'h1 << $urandom_range(0, 47));
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        clock_now = clock_now + $urandom_range(0, 3);
        queue_sighting(mac, 8'($urandom_range(0, 255)), clock_now);
      end else if (pick < 75) begin
        queue_sighting(mac, 8'($urandom_range(0, 255)), $urandom());
      end else if (pick < 88) begin
        queue_sighting(mac, 8'($urandom_range(0, 255)), 32'h0);
      end else begin
        queue_sighting(mac, 8'($urandom_range(0, 255)), 32'hFFFF_FFFF);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (sighting_pending_q.size() > 0 || start || sighting_expect_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sighting_expect_q.size() != 0)
      report_mismatch("results never delivered", 64'(sighting_expect_q.size()), 64'(0));
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sighting_table_upsert_evict_oldest.f
rtl/sta_pkg.sv
rtl/sta_front.sv
rtl/sta_back.sv
rtl/sighting_table_upsert_evict_oldest.sv
tb/sighting_table_upsert_evict_oldest_test.sv
